[sv/kwm_pkg.sv]
// Package for the sorted-run merger: operation, result kind and sequencer codes.
// No dependencies.
package kwm_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned TagW   = 64;
  localparam int unsigned RunW   = 3;
  localparam int unsigned ChunkW = 13;
  localparam int unsigned CountW = 12;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned ChunkMax = 4096;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_END   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_ROW    = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_POP
  } state_e;

  typedef enum logic {
    REG_CHUNK_LEN  = 1'b0,
    REG_KEY_SIGNED = 1'b1
  } reg_e;

endpackage

[sv/kwm_if.sv]
// Beat channels of the sorted-run merger: input items and result items.
// Depends on kwm_pkg.
interface kwm_in_if import kwm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [RunW-1:0]        run_index;
  logic signed [KeyW-1:0] key_in;
  logic [TagW-1:0]        row_tag_in;

  modport source (output valid, op, run_index, key_in, row_tag_in, input ready);
  modport sink (input valid, op, run_index, key_in, row_tag_in, output ready);
endinterface

interface kwm_out_if import kwm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic signed [KeyW-1:0] key_out;
  logic [RunW-1:0]        source_run;
  logic [TagW-1:0]        row_tag_out;
  logic                   chunk_end;
  logic                   merge_done;
  logic                   last;

  modport source (output valid, kind, key_out, source_run, row_tag_out, chunk_end,
                  merge_done, last, input ready);
  modport sink (input valid, kind, key_out, source_run, row_tag_out, chunk_end,
                merge_done, last, output ready);
endinterface

[sv/kway_sorted_run_merger_unit.sv]
// Sequence: an input beat is applied in ST_EXEC; each merged row then takes a scan of all RUNS
// run heads (one read of the shared row memory and one key compare per run head), a drain, a pop.
// An input beat releases up to 64 rows; a rejected push, clear or no-op releases none. A new
// input beat is taken only in ST_IDLE, once the last one is through. Output stalls hold the sequencer.
// Reset: queues empty, no run ended, chunk count zero, chunk length 4096, key_signed 1.
// Row memory contents are not cleared; only heads of non-empty queues enter the compare.
module kway_sorted_run_merger_unit import kwm_pkg::*; #(
  parameter int unsigned RUNS        = 8,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kwm_in_if.sink       in_i,
  kwm_out_if.source    out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned RW    = $clog2(RUNS);
  localparam int unsigned HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned Slots = RUNS * QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(Slots);
  localparam int unsigned NW    = $clog2(MaxResults + 1);
  localparam int unsigned IW    = (RW > RunW) ? RW + 1 : RunW + 1;

  // Registers
  logic [ChunkW-1:0] chunk_len_q;
  logic              key_signed_q;
  logic              cfg_wr;

  // Sequencer and item
  state_e          state_q, state_d;
  logic [1:0]      op_q;
  logic [RunW-1:0] run_q;
  logic [KeyW-1:0] key_q;
  logic [TagW-1:0] tag_q;
  logic            newly_q, newly_d;
  logic [NW-1:0]   n_q, n_d;

  // Queue state
  logic [FW-1:0] fill_q [RUNS];
  logic [FW-1:0] fill_d [RUNS];
  logic [HW-1:0] head_q [RUNS];
  logic [HW-1:0] head_d [RUNS];
  logic          ended_q [RUNS];
  logic          ended_d [RUNS];
  logic [CountW-1:0] rows_q, rows_d;

  // Row memory
  logic [KeyW+TagW-1:0] mem [Slots];
  logic [KeyW+TagW-1:0] rdata_q;
  logic [AW-1:0]        raddr;
  logic                 mem_we;
  logic [AW-1:0]        waddr;

  // Scan
  logic [RW-1:0]   sc_q, sc_d;
  logic            pend_q, pend_d;
  logic [RW-1:0]   pend_run_q;
  logic            found_q, found_d;
  logic [RW-1:0]   best_q, best_d;
  logic [KeyW-1:0] bkey_q, bkey_d;
  logic [TagW-1:0] btag_q, btag_d;

  // Held row and output register
  logic            hold_q, hold_d;
  logic            hce_q, hce_d, hmd_q, hmd_d;
  logic            ov_q, ov_d;
  logic [1:0]      okind_q, okind_d;
  logic [KeyW-1:0] okey_q, okey_d;
  logic [RunW-1:0] orun_q, orun_d;
  logic [TagW-1:0] otag_q, otag_d;
  logic            oce_q, oce_d, omd_q, omd_d, olast_q, olast_d;

  logic            out_free;
  logic            in_acc;
  logic [RW-1:0]   rsel;
  logic            run_ok;
  logic            can_emit;
  logic            any_fill;
  logic            all_done;
  logic            done_after_pop;
  logic [ChunkW-1:0] eff_chunk;
  logic [ChunkW-1:0] rows_inc;
  logic [KeyW-1:0] cmp_a, cmp_b;
  logic            key_lt;
  logic [HW:0]     pos_sum;
  logic [HW-1:0]   pos;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_e'(paddr[2]))
      REG_CHUNK_LEN:  prdata = 32'(chunk_len_q);
      REG_KEY_SIGNED: prdata = 32'(key_signed_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_len_q  <= ChunkW'(ChunkMax);
      key_signed_q <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_CHUNK_LEN:  chunk_len_q <= pwdata[ChunkW-1:0];
        REG_KEY_SIGNED: key_signed_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !ov_q || out_o.ready;

  assign out_o.valid       = ov_q;
  assign out_o.kind        = okind_q;
  assign out_o.key_out     = okey_q;
  assign out_o.source_run  = orun_q;
  assign out_o.row_tag_out = otag_q;
  assign out_o.chunk_end   = oce_q;
  assign out_o.merge_done  = omd_q;
  assign out_o.last        = olast_q;

  // Run decode and queue status
  assign rsel   = RW'(run_q);
  assign run_ok = IW'(run_q) < IW'(RUNS);

  always_comb begin
    any_fill = 1'b0;
    can_emit = 1'b1;
    all_done = 1'b1;
    done_after_pop = 1'b1;
    for (int r = 0; r < RUNS; r++) begin
      if (fill_q[r] != '0) any_fill = 1'b1;
      else if (!ended_q[r]) can_emit = 1'b0;
      if (!ended_q[r] || fill_q[r] != '0) all_done = 1'b0;
      if (!ended_q[r] ||
          !(fill_q[r] == '0 || (RW'(r) == best_q && fill_q[r] == FW'(1))))
        done_after_pop = 1'b0;
    end
    can_emit = can_emit && any_fill;
  end

  // Effective chunk length and count step
  always_comb begin
    if (chunk_len_q == '0) eff_chunk = ChunkW'(1);
    else if (chunk_len_q > ChunkW'(ChunkMax)) eff_chunk = ChunkW'(ChunkMax);
    else eff_chunk = chunk_len_q;
  end
  assign rows_inc = ChunkW'(rows_q) + ChunkW'(1);

  // Tail slot of the addressed queue
  assign pos_sum = (HW+1)'(head_q[rsel]) + (HW+1)'(fill_q[rsel]);
  assign pos = (pos_sum >= (HW+1)'(QUEUE_DEPTH)) ?
               HW'(pos_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(pos_sum);
  assign waddr = AW'(rsel) * AW'(QUEUE_DEPTH) + AW'(pos);
  assign raddr = AW'(sc_q) * AW'(QUEUE_DEPTH) + AW'(head_q[sc_q]);

  // Shared key compare: biased for signed order when key_signed is set
  assign cmp_a  = rdata_q[KeyW+TagW-1:TagW] ^ {key_signed_q, {(KeyW-1){1'b0}}};
  assign cmp_b  = bkey_q ^ {key_signed_q, {(KeyW-1){1'b0}}};
  assign key_lt = cmp_a < cmp_b;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_EXEC;
      ST_EXEC: begin
        unique case (op_e'(op_q))
          OP_PUSH: begin
            if (!run_ok || ended_q[rsel] || fill_q[rsel] == FW'(QUEUE_DEPTH)) begin
              if (out_free) state_d = ST_IDLE;
            end else begin
              state_d = ST_CHECK;
            end
          end
          OP_END: state_d = (!run_ok || ended_q[rsel]) ? ST_IDLE : ST_CHECK;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_CHECK: begin
        if (hold_q) begin
          if (out_free) begin
            state_d = (n_q < NW'(MaxResults) && can_emit) ? ST_SCAN : ST_IDLE;
          end
        end else if (n_q < NW'(MaxResults) && can_emit) begin
          state_d = ST_SCAN;
        end else if (n_q == '0 && newly_q && all_done) begin
          if (out_free) state_d = ST_IDLE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN:  if (sc_q == RW'(RUNS - 1)) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_POP;
      ST_POP:   state_d = ST_CHECK;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    newly_d = newly_q;
    n_d     = n_q;
    fill_d  = fill_q;
    head_d  = head_q;
    ended_d = ended_q;
    rows_d  = rows_q;
    mem_we  = 1'b0;
    sc_d    = sc_q;
    pend_d  = 1'b0;
    found_d = found_q;
    best_d  = best_q;
    bkey_d  = bkey_q;
    btag_d  = btag_q;
    hold_d  = hold_q;
    hce_d   = hce_q;
    hmd_d   = hmd_q;
    ov_d    = ov_q && !out_o.ready;
    okind_d = okind_q;
    okey_d  = okey_q;
    orun_d  = orun_q;
    otag_d  = otag_q;
    oce_d   = oce_q;
    omd_d   = omd_q;
    olast_d = olast_q;

    // fold the pending head into the running minimum
    if (pend_q && (!found_q || key_lt)) begin
      found_d = 1'b1;
      best_d  = pend_run_q;
      bkey_d  = rdata_q[KeyW+TagW-1:TagW];
      btag_d  = rdata_q[TagW-1:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          newly_d = 1'b0;
          n_d     = '0;
          hold_d  = 1'b0;
        end
      end
      ST_EXEC: begin
        unique case (op_e'(op_q))
          OP_PUSH: begin
            if (!run_ok || ended_q[rsel] || fill_q[rsel] == FW'(QUEUE_DEPTH)) begin
              if (out_free) begin
                ov_d    = 1'b1;
                okind_d = KIND_REJECT;
                okey_d  = '0;
                orun_d  = run_q;
                otag_d  = '0;
                oce_d   = 1'b0;
                omd_d   = 1'b0;
                olast_d = 1'b1;
              end
            end else begin
              mem_we       = 1'b1;
              fill_d[rsel] = fill_q[rsel] + FW'(1);
            end
          end
          OP_END: begin
            if (run_ok && !ended_q[rsel]) begin
              ended_d[rsel] = 1'b1;
              newly_d       = 1'b1;
            end
          end
          OP_CLEAR: begin
            for (int r = 0; r < RUNS; r++) begin
              fill_d[r]  = '0;
              head_d[r]  = '0;
              ended_d[r] = 1'b0;
            end
            rows_d = '0;
          end
          default: ;
        endcase
      end
      ST_CHECK: begin
        sc_d    = '0;
        found_d = 1'b0;
        if (hold_q) begin
          if (out_free) begin
            ov_d    = 1'b1;
            okind_d = KIND_ROW;
            okey_d  = bkey_q;
            orun_d  = RunW'(best_q);
            otag_d  = btag_q;
            oce_d   = hce_q;
            omd_d   = hmd_q;
            olast_d = !(n_q < NW'(MaxResults) && can_emit);
            hold_d  = 1'b0;
          end
        end else if (!(n_q < NW'(MaxResults) && can_emit) &&
                     n_q == '0 && newly_q && all_done && out_free) begin
          ov_d    = 1'b1;
          okind_d = KIND_DONE;
          okey_d  = '0;
          orun_d  = '0;
          otag_d  = '0;
          oce_d   = (rows_q != '0);
          omd_d   = 1'b1;
          olast_d = 1'b1;
          rows_d  = '0;
        end
      end
      ST_SCAN: begin
        pend_d = (fill_q[sc_q] != '0);
        if (sc_q != RW'(RUNS - 1)) sc_d = sc_q + RW'(1);
      end
      ST_POP: begin
        fill_d[best_q] = fill_q[best_q] - FW'(1);
        head_d[best_q] = (head_q[best_q] == HW'(QUEUE_DEPTH - 1)) ?
                         '0 : head_q[best_q] + HW'(1);
        hmd_d  = done_after_pop;
        hold_d = 1'b1;
        n_d    = n_q + NW'(1);
        if (rows_inc >= eff_chunk || done_after_pop) begin
          hce_d  = 1'b1;
          rows_d = '0;
        end else begin
          hce_d  = 1'b0;
          rows_d = rows_inc[CountW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      newly_q <= 1'b0;
      n_q     <= '0;
      rows_q  <= '0;
      sc_q    <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      hold_q  <= 1'b0;
      ov_q    <= 1'b0;
      for (int r = 0; r < RUNS; r++) begin
        fill_q[r]  <= '0;
        head_q[r]  <= '0;
        ended_q[r] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      newly_q <= newly_d;
      n_q     <= n_d;
      rows_q  <= rows_d;
      sc_q    <= sc_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      hold_q  <= hold_d;
      ov_q    <= ov_d;
      fill_q  <= fill_d;
      head_q  <= head_d;
      ended_q <= ended_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_i.op;
      run_q <= in_i.run_index;
      key_q <= in_i.key_in;
      tag_q <= in_i.row_tag_in;
    end
    pend_run_q <= sc_q;
    best_q  <= best_d;
    bkey_q  <= bkey_d;
    btag_q  <= btag_d;
    hce_q   <= hce_d;
    hmd_q   <= hmd_d;
    okind_q <= okind_d;
    okey_q  <= okey_d;
    orun_q  <= orun_d;
    otag_q  <= otag_d;
    oce_q   <= oce_d;
    omd_q   <= omd_d;
    olast_q <= olast_d;
  end

  // Row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= {key_q, tag_q};
    rdata_q <= mem[raddr];
  end

endmodule
